@@ sv/qrs_pkg.sv @@
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;

   localparam int PROD_BITS  = 2 * WORD_BITS;
   // b^2 +/- 4ac needs two bits over the product
   localparam int DISC_BITS  = 2 * WORD_BITS + 2;
   localparam int ROOT_BITS  = DISC_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   // -b +/- sqrt, signed
   localparam int NUM_BITS   = WORD_BITS + 3;
   localparam int MAG_BITS   = WORD_BITS + 2;
   // |2a|
   localparam int DEN_BITS   = WORD_BITS + 1;
   localparam int QUO_BITS   = MAG_BITS + FRAC_BITS;
   localparam int DREM_BITS  = DEN_BITS + 1;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   localparam int STATUS_BITS = 2;
   localparam logic [STATUS_BITS-1:0] ST_REAL     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NEG_DISC = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_A_ZERO   = 2'd2;

   // classified coefficient set handed from front to back
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   coef_a;
      logic [WORD_BITS-1:0]   coef_b;
      logic [DISC_BITS-1:0]   disc;
   } qrs_entry_type;

endpackage

@@ sv/qrs_if.sv @@
`timescale 1ns / 1ps

interface qrs_req_if;
   import qrs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] coef_a;
   logic signed [WORD_BITS-1:0] coef_b;
   logic signed [WORD_BITS-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_rsp_if;
   import qrs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] root_plus;
   logic signed [WORD_BITS-1:0] root_minus;
   logic [STATUS_BITS-1:0]      status;
   logic                        saturated;

   modport source (output valid, output root_plus, output root_minus, output status,
                   output saturated, input ready);
   modport sink   (input valid, input root_plus, input root_minus, input status,
                   input saturated, output ready);
endinterface

@@ sv/quadratic_root_solver.sv @@
`timescale 1ns / 1ps

// Real-root solver for a*x^2 + b*x + c, all values signed Q16.16.
// req_chan carries one coefficient set (coef_a, coef_b, coef_c) per
// transaction; rsp_chan returns one result per set, in order: root_plus,
// root_minus, status (real roots / negative discriminant / a is zero) and
// saturated (a root was clamped to the word range).
// Throughput: one transaction per cycle while nothing stalls. Every
// stage holds a 32x32 product, one wide add/compare or one digit of
// the square root or of the quotient.
// Path from accept to rsp valid: 3 front stages, the queue, W+2
// square-root stages (load plus W+1 digits), 2 numerator stages,
// W+2+F quotient bit stages (both roots in parallel), 1 output reg.
// The front stalls only when the 4-entry queue is full; the back pipeline
// freezes while rsp valid is held and not taken, and the queue absorbs
// what the front still has in flight.
// Reset (synchronous, active high) empties the pipelines and the queue;
// no clearing pass is needed and req_chan.ready follows right away.
module quadratic_root_solver (
   input  logic       clock,
   input  logic       reset,
   qrs_req_if.sink    req_chan,
   qrs_rsp_if.source  rsp_chan
);
   import qrs_pkg::*;

   // front -> queue
   logic          push_valid, push_ready;
   qrs_entry_type push_entry;
   // queue -> back
   logic          pop_valid, pop_ready;
   qrs_entry_type pop_entry;

   // classify and form the discriminant
   qrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decouples front stalls from back stalls
   qrs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // square root, the two divisions and saturation
   qrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ sv/qrs_front.sv @@
`timescale 1ns / 1ps

module qrs_front (
   input  logic                  clock,
   input  logic                  reset,
   qrs_req_if.sink               req_chan,
   output logic                  push_valid,
   input  logic                  push_ready,
   output qrs_pkg::qrs_entry_type push_entry
);
   import qrs_pkg::*;

   logic                 en;
   logic                 v1_ff, v2_ff, v3_ff;

   // stage 1: magnitudes
   logic [WORD_BITS-1:0] a1_ff, b1_ff;
   logic [WORD_BITS-1:0] abs_a_ff, abs_b_ff, abs_c_ff;
   logic [WORD_BITS-1:0] abs_a_in, abs_b_in, abs_c_in;
   logic                 sdiff1_ff, azero1_ff;

   // stage 2: products
   logic [PROD_BITS-1:0] bb_ff, ac_ff, bb_in, ac_in;
   logic [WORD_BITS-1:0] a2_ff, b2_ff;
   logic                 sdiff2_ff, azero2_ff;

   // stage 3: discriminant and class
   qrs_entry_type        entry_ff, entry_in;
   logic [DISC_BITS-1:0] bb_ext, ac4;

   always_comb begin
      en             = !v3_ff || push_ready;
      req_chan.ready = en;

      abs_a_in = req_chan.coef_a[WORD_BITS-1] ? WORD_BITS'(-req_chan.coef_a)
                                              : WORD_BITS'(req_chan.coef_a);
      abs_b_in = req_chan.coef_b[WORD_BITS-1] ? WORD_BITS'(-req_chan.coef_b)
                                              : WORD_BITS'(req_chan.coef_b);
      abs_c_in = req_chan.coef_c[WORD_BITS-1] ? WORD_BITS'(-req_chan.coef_c)
                                              : WORD_BITS'(req_chan.coef_c);

      bb_in = PROD_BITS'(abs_b_ff) * PROD_BITS'(abs_b_ff);
      ac_in = PROD_BITS'(abs_a_ff) * PROD_BITS'(abs_c_ff);

      bb_ext = DISC_BITS'(bb_ff);
      ac4    = {ac_ff, 2'b00};
      entry_in.coef_a = a2_ff;
      entry_in.coef_b = b2_ff;
      entry_in.disc   = sdiff2_ff ? (bb_ext + ac4) : (bb_ext - ac4);
      if (azero2_ff) begin
         entry_in.status = ST_A_ZERO;
      end else if (entry_in.disc[DISC_BITS-1]) begin
         entry_in.status = ST_NEG_DISC;
      end else begin
         entry_in.status = ST_REAL;
      end

      push_valid = v3_ff;
      push_entry = entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= req_chan.coef_a;
         b1_ff     <= req_chan.coef_b;
         abs_a_ff  <= abs_a_in;
         abs_b_ff  <= abs_b_in;
         abs_c_ff  <= abs_c_in;
         sdiff1_ff <= req_chan.coef_a[WORD_BITS-1] ^ req_chan.coef_c[WORD_BITS-1];
         azero1_ff <= (req_chan.coef_a == '0);

         bb_ff     <= bb_in;
         ac_ff     <= ac_in;
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         sdiff2_ff <= sdiff1_ff;
         azero2_ff <= azero1_ff;

         entry_ff  <= entry_in;
      end
   end

endmodule

@@ sv/qrs_fifo.sv @@
`timescale 1ns / 1ps

module qrs_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  qrs_pkg::qrs_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output qrs_pkg::qrs_entry_type pop_entry
);
   import qrs_pkg::*;

   qrs_entry_type       mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                push, pop;

   always_comb begin
      push_ready = (count_ff < CNT_BITS'(FIFO_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_entry  = mem_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(FIFO_DEPTH))
      else $error("fifo count beyond depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("fifo push lost");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("fifo pop lost");

endmodule

@@ sv/qrs_back.sv @@
`timescale 1ns / 1ps

module qrs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  qrs_pkg::qrs_entry_type pop_entry,
   qrs_rsp_if.source              rsp_chan
);
   import qrs_pkg::*;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   a;
      logic [WORD_BITS-1:0]   b;
      logic [DISC_BITS-1:0]   rad;
      logic [REM_BITS-1:0]    rem;
      logic [ROOT_BITS-1:0]   root;
   } sq_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]     status;
      logic signed [NUM_BITS-1:0] np;
      logic signed [NUM_BITS-1:0] nm;
      logic signed [DEN_BITS-1:0] den2;
   } mid_type;

   typedef struct packed {
      logic                 neg;
      logic [QUO_BITS-1:0]  n;
      logic [DREM_BITS-1:0] r;
      logic [QUO_BITS-1:0]  q;
   } lane_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [DEN_BITS-1:0]    den;
      lane_type               p;
      lane_type               m;
   } dv_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 sat;
   } fin_type;

   localparam logic [QUO_BITS-1:0] NEG_LIM = QUO_BITS'(1) << (WORD_BITS - 1);
   localparam logic [QUO_BITS-1:0] POS_LIM = NEG_LIM - 1'b1;

   // one restoring square-root digit
   function automatic sq_type sqrt_step(sq_type s);
      sq_type              o;
      logic [REM_BITS-1:0] sh, trial;
      o     = s;
      sh    = {s.rem[REM_BITS-3:0], s.rad[DISC_BITS-1 -: 2]};
      trial = {s.root, 2'b01};
      o.rad = {s.rad[DISC_BITS-3:0], 2'b00};
      if (sh >= trial) begin
         o.rem  = sh - trial;
         o.root = {s.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         o.rem  = sh;
         o.root = {s.root[ROOT_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

   // one restoring division bit
   function automatic lane_type div_step(lane_type l, logic [DEN_BITS-1:0] d);
      lane_type             o;
      logic [DREM_BITS-1:0] sh, dext;
      logic                 ge;
      o    = l;
      sh   = {l.r[DREM_BITS-2:0], l.n[QUO_BITS-1]};
      dext = {1'b0, d};
      ge   = (sh >= dext);
      o.n  = {l.n[QUO_BITS-2:0], 1'b0};
      o.r  = ge ? (sh - dext) : sh;
      o.q  = {l.q[QUO_BITS-2:0], ge};
      return o;
   endfunction

   function automatic lane_type lane_load(logic signed [NUM_BITS-1:0] num, logic dneg);
      lane_type            o;
      logic [MAG_BITS-1:0] mag;
      mag   = num[NUM_BITS-1] ? MAG_BITS'(-num) : MAG_BITS'(num);
      o.neg = num[NUM_BITS-1] ^ dneg;
      o.n   = QUO_BITS'(mag) << FRAC_BITS;
      o.r   = '0;
      o.q   = '0;
      return o;
   endfunction

   function automatic fin_type lane_final(lane_type l);
      fin_type o;
      if (!l.neg) begin
         o.sat = (l.q > POS_LIM);
         o.val = o.sat ? POS_LIM[WORD_BITS-1:0] : l.q[WORD_BITS-1:0];
      end else begin
         o.sat = (l.q > NEG_LIM);
         o.val = o.sat ? NEG_LIM[WORD_BITS-1:0] : WORD_BITS'(-l.q[WORD_BITS-1:0]);
      end
      return o;
   endfunction

   logic                 en;
   sq_type               sq_ff [0:ROOT_BITS];
   logic [ROOT_BITS:0]   sq_vld_ff;
   mid_type              mid_ff, mid_in;
   logic                 mid_vld_ff;
   dv_type               dv_ff [0:QUO_BITS];
   dv_type               dv0_in;
   logic [QUO_BITS:0]    dv_vld_ff;
   sq_type               sq0_in;
   fin_type              fin_p, fin_m;

   logic signed [WORD_BITS-1:0] root_plus_ff, root_minus_ff;
   logic signed [WORD_BITS-1:0] root_plus_in, root_minus_in;
   logic [STATUS_BITS-1:0]      status_ff;
   logic                        sat_ff, sat_in, out_vld_ff;

   always_comb begin
      en        = !out_vld_ff || rsp_chan.ready;
      pop_ready = en;

      sq0_in.status = pop_entry.status;
      sq0_in.a      = pop_entry.coef_a;
      sq0_in.b      = pop_entry.coef_b;
      sq0_in.rad    = pop_entry.disc;
      sq0_in.rem    = '0;
      sq0_in.root   = '0;

      mid_in.status = sq_ff[ROOT_BITS].status;
      mid_in.np     = -NUM_BITS'($signed(sq_ff[ROOT_BITS].b))
                      + $signed(NUM_BITS'(sq_ff[ROOT_BITS].root));
      mid_in.nm     = -NUM_BITS'($signed(sq_ff[ROOT_BITS].b))
                      - $signed(NUM_BITS'(sq_ff[ROOT_BITS].root));
      mid_in.den2   = $signed({sq_ff[ROOT_BITS].a, 1'b0});

      dv0_in.status = mid_ff.status;
      dv0_in.den    = mid_ff.den2[DEN_BITS-1] ? DEN_BITS'(-mid_ff.den2)
                                              : DEN_BITS'(mid_ff.den2);
      dv0_in.p      = lane_load(mid_ff.np, mid_ff.den2[DEN_BITS-1]);
      dv0_in.m      = lane_load(mid_ff.nm, mid_ff.den2[DEN_BITS-1]);

      fin_p = lane_final(dv_ff[QUO_BITS].p);
      fin_m = lane_final(dv_ff[QUO_BITS].m);
      if (dv_ff[QUO_BITS].status == ST_REAL) begin
         root_plus_in  = $signed(fin_p.val);
         root_minus_in = $signed(fin_m.val);
         sat_in        = fin_p.sat || fin_m.sat;
      end else begin
         root_plus_in  = '0;
         root_minus_in = '0;
         sat_in        = 1'b0;
      end

      rsp_chan.valid      = out_vld_ff;
      rsp_chan.root_plus  = root_plus_ff;
      rsp_chan.root_minus = root_minus_ff;
      rsp_chan.status     = status_ff;
      rsp_chan.saturated  = sat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= '0;
         mid_vld_ff <= 1'b0;
         dv_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         sq_vld_ff  <= {sq_vld_ff[ROOT_BITS-1:0], pop_valid};
         mid_vld_ff <= sq_vld_ff[ROOT_BITS];
         dv_vld_ff  <= {dv_vld_ff[QUO_BITS-1:0], mid_vld_ff};
         out_vld_ff <= dv_vld_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq0_in;
         for (int k = 0; k < ROOT_BITS; k++) begin
            sq_ff[k+1] <= sqrt_step(sq_ff[k]);
         end
         mid_ff   <= mid_in;
         dv_ff[0] <= dv0_in;
         for (int j = 0; j < QUO_BITS; j++) begin
            dv_ff[j+1].status <= dv_ff[j].status;
            dv_ff[j+1].den    <= dv_ff[j].den;
            dv_ff[j+1].p      <= div_step(dv_ff[j].p, dv_ff[j].den);
            dv_ff[j+1].m      <= div_step(dv_ff[j].m, dv_ff[j].den);
         end
         root_plus_ff  <= root_plus_in;
         root_minus_ff <= root_minus_in;
         status_ff     <= dv_ff[QUO_BITS].status;
         sat_ff        <= sat_in;
      end
   end

   a_sat_real: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && sat_ff |-> status_ff == ST_REAL)
      else $error("saturation flagged without real roots");

   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && status_ff != ST_REAL |-> root_plus_ff == '0 && root_minus_ff == '0)
      else $error("roots not cleared for non-real status");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(sq_vld_ff) && $stable(dv_vld_ff) && $stable(mid_vld_ff))
      else $error("pipeline moved during stall");

   a_pop_enter: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> sq_vld_ff[0])
      else $error("popped transaction did not enter pipeline");

endmodule

@@ bench/qrs_if.sv @@
`timescale 1ns / 1ps

// Interface definitions live with the RTL; nothing extra needed here.
// (The RTL's sv/qrs_if.sv provides qrs_req_if and qrs_rsp_if.)
package qrs_tb_pkg;
   import qrs_pkg::*;
   // one predicted root pair
   typedef struct packed {
      logic signed [WORD_BITS-1:0] root_plus;
      logic signed [WORD_BITS-1:0] root_minus;
      logic [STATUS_BITS-1:0]      status;
      logic                        saturated;
   } root_pair_type;
endpackage

@@ bench/tb_quadratic_root_solver.sv @@
`timescale 1ns / 1ps

module tb_quadratic_root_solver;
   import qrs_pkg::*;
   import qrs_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   int   sets_sent = 0;
   int   results_seen = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 1'b0;
   bit   all_sent = 1'b0;

   qrs_req_if req_chan ();
   qrs_rsp_if rsp_chan ();

   quadratic_root_solver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Golden root computation. Widths are generous so no intermediate wraps.
   function automatic root_pair_type solve_roots(logic signed [31:0] a,
                                                 logic signed [31:0] b,
                                                 logic signed [31:0] c);
      root_pair_type r;
      logic signed [69:0] disc;
      logic [69:0] dmag, rt, bitv, t;
      logic signed [69:0] nb, np, nm, den;
      r = '0;
      if (a == 0) begin
         r.status = ST_A_ZERO;
         return r;
      end
      disc = 70'(b) * 70'(b) - 70'sd4 * 70'(a) * 70'(c);
      if (disc < 0) begin
         r.status = ST_NEG_DISC;
         return r;
      end
      // bitwise floor square root
      dmag = disc;
      rt = '0;
      bitv = 70'd1 << 68;
      while (bitv > dmag) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = rt + bitv;
         if (dmag >= t) begin
            dmag = dmag - t;
            rt = (rt >> 1) + bitv;
         end else begin
            rt = rt >> 1;
         end
         bitv = bitv >> 2;
      end
      nb  = -70'(b);
      den = 70'(a) * 2;
      np  = nb + $signed(rt);
      nm  = nb - $signed(rt);
      r.status = ST_REAL;
      r.root_plus  = quot_sat(np, den, r.saturated);
      r.root_minus = quot_sat(nm, den, r.saturated);
      return r;
   endfunction

   // num*2^16/den truncated toward zero, clamped to 32 bits
   function automatic logic [31:0] quot_sat(logic signed [69:0] num,
                                            logic signed [69:0] den,
                                            inout logic sat);
      logic [89:0] n, d, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? 90'(-num) : 90'(num);
      d = (den < 0) ? 90'(-den) : 90'(den);
      q = (n << FRAC_BITS) / d;
      if (!neg) begin
         if (q > 90'h7fffffff) begin
            sat = 1'b1;
            return 32'h7fffffff;
         end
         return q[31:0];
      end
      if (q > 90'h80000000) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return 32'(-q[31:0]);
   endfunction

   class root_scoreboard;
      root_pair_type pending[$];
      function void note_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
         pending.push_back(solve_roots(a, b, c));
      endfunction
      task check_result(root_pair_type got);
         root_pair_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", got.root_plus, 0);
            return;
         end
         want = pending.pop_front();
         if (got.root_plus !== want.root_plus)
            report_mismatch("root_plus", got.root_plus, want.root_plus);
         if (got.root_minus !== want.root_minus)
            report_mismatch("root_minus", got.root_minus, want.root_minus);
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
         if (got.saturated !== want.saturated)
            report_mismatch("saturated", got.saturated, want.saturated);
      endtask
   endclass

   root_scoreboard roots_sb = new();

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.coef_a = '0;
      req_chan.coef_b = '0;
      req_chan.coef_c = '0;
      rsp_chan.ready  = 1'b0;
   end

   // Receiver: stall decided at the falling edge, sample at the rising edge.
   always @(negedge clock) begin
      if (reset || hold_off)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      root_pair_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.root_plus  = rsp_chan.root_plus;
         got.root_minus = rsp_chan.root_minus;
         got.status     = rsp_chan.status;
         got.saturated  = rsp_chan.saturated;
         roots_sb.check_result(got);
         results_seen++;
      end
   end

   // Offer one coefficient set; wait until accepted. valid stays high
   // across back-to-back transactions.
   task automatic send_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.coef_a <= a;
      req_chan.coef_b <= b;
      req_chan.coef_c <= c;
      do @(posedge clock); while (!req_chan.ready);
      roots_sb.note_set(a, b, c);
      sets_sent++;
      @(negedge clock);
   endtask

   // Random field: mostly moderate Q16.16 values, sometimes full range.
   function automatic logic [31:0] rand_coef();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
         2:       return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         3:       return 32'($signed($urandom_range(200)) - 100) <<< 16;
         4:       return 0;
         default: return 32'($signed($urandom_range(65536 * 200)) - 65536 * 100);
      endcase
   endfunction

   task automatic run_phase(int n, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) send_set(rand_coef(), rand_coef(), rand_coef());
   endtask

   initial begin
      logic [31:0] edge_vals[6];
      edge_vals = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff,
                    32'h00010000, 32'h00000001};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: a zero, negative discriminant, double root, clamping.
      send_set(32'h0, 32'h00010000, 32'h00020000);
      send_set(32'h0, 32'h80000000, 32'h7fffffff);
      send_set(32'h00010000, 32'h0, 32'h00010000);
      send_set(32'h00010000, 32'hfffe0000, 32'h00010000);
      send_set(32'h00010000, 32'h0, 32'hffff0000);
      send_set(32'h00000001, 32'h7fffffff, 32'h0);
      send_set(32'h00000001, 32'h80000000, 32'h80000000);
      send_set(32'hffffffff, 32'h80000000, 32'h7fffffff);
      for (int i = 0; i < 6; i++)
         send_set(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6]);
      send_set(32'h80000000, 32'h80000000, 32'h80000000);
      send_set(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_set(32'h80000000, 32'h7fffffff, 32'h7fffffff);

      run_phase(150, 0, 0);
      run_phase(140, 52, 0);
      // long receiver hold-off while the sender keeps offering; more sets
      // than the pipelines and queue hold, so the input stalls
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         run_phase(150, 0, 0);
      join
      run_phase(120, 0, 52);
      run_phase(120, 20, 20);
      req_chan.valid <= 1'b0;
      all_sent = 1'b1;
   end

   // Ending: all sent, queue drained, then a margin before the report.
   initial begin
      wait (all_sent);
      wait (roots_sb.pending.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d coefficient sets, checked %0d root results", sets_sent,
               results_seen);
      $display("covered a=0, negative discriminant, saturation, idle and stall mixes");
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/qrs_pkg.sv
sv/qrs_if.sv
sv/qrs_front.sv
sv/qrs_fifo.sv
sv/qrs_back.sv
sv/quadratic_root_solver.sv
bench/qrs_if.sv
bench/tb_quadratic_root_solver.sv
